// File: hdl/ldc_pkg.sv
// ----------------------------------------------------------------------------
// ldc_pkg
// Shared constants and command/status types for the dominance chain unit.
// ----------------------------------------------------------------------------
package ldc_pkg;
	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = 7;

	typedef struct packed {
		logic        load;       // accept a word into the sorted store
		logic [15:0] load_w;
		logic [15:0] load_s;
		logic        shift;      // move the compared entry up one place
		logic        place;      // write the new entry at the insertion point
		logic        dp_init;    // start the DP sweep at the top row
		logic        row_start;  // fetch entry of the current row
		logic        row_cap;    // latch row keys, fetch first candidate
		logic        scan;       // compare one candidate, fetch the next
		logic        row_end;    // store row result, step to the row below
		logic        tr_read;    // fetch the chain element at pos
		logic        tr_load;    // fill the result register
		logic        tr_pop;     // downstream took the result word
	} ldc_cmd_t;

	typedef struct packed {
		logic             shift_ok;  // compared entry heavier than the new one
		logic             j_end;     // no candidate above the row
		logic             j_last;    // current candidate is the top one
		logic             row_zero;  // bottom row reached
		logic             out_valid;
		logic [CNT_W-1:0] out_len;
		logic [CNT_W-1:0] out_item;
		logic             out_end;
	} ldc_stat_t;
endpackage

// File: hdl/longest_dominance_chain_unit.sv
// Each word is inserted into the weight-sorted store, shifting up every heavier
// item already held. The last word then starts a DP sweep over the n held
// items; the chain is then read out one result word at a time, each held
// until downstream takes it.
// One set at a time; input held off during each insertion and from last word to last result.
// Reset (arst_n low): count, overflow flag and control clear; stores are not.
// ----------------------------------------------------------------------------
// longest_dominance_chain_unit
// Longest chain of rising weight and falling speed over a loaded set.
// ----------------------------------------------------------------------------
module longest_dominance_chain_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] weight, [31:16] speed
	input  logic        s_tlast,  // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [6:0] chain_length, [13:7] item_number, [15:14] 0
	output logic        m_tuser,  // overflow
	output logic        m_tlast   // end_of_chain
);
	ldc_pkg::ldc_cmd_t  cmd;
	ldc_pkg::ldc_stat_t stat;
	logic [ldc_pkg::CNT_W-1:0] count;
	logic ovf;

	ldc_control u_ctl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_w(s_tdata[15:0]), .in_s(s_tdata[31:16]),
		.in_last(s_tlast), .in_ready(s_tready), .out_ready(m_tready),
		.stat, .cmd, .count, .ovf
	);

	ldc_datapath u_dp (.clk, .arst_n, .cmd, .count, .stat);

	assign m_tvalid = stat.out_valid;
	assign m_tdata  = {2'b00, stat.out_item, stat.out_len};
	assign m_tuser  = ovf;
	assign m_tlast  = stat.out_end;
endmodule

// File: hdl/ldc_datapath.sv
// ----------------------------------------------------------------------------
// ldc_datapath
// Weight-sorted item store, DP sweep registers and chain trace output.
// ----------------------------------------------------------------------------
module ldc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ldc_pkg::ldc_cmd_t cmd,
	input  logic [ldc_pkg::CNT_W-1:0] count,
	output ldc_pkg::ldc_stat_t stat
);
	localparam int IW = ldc_pkg::IDX_W;
	localparam int CW = ldc_pkg::CNT_W;
	localparam int N  = ldc_pkg::MAX_ITEMS;

	typedef struct packed {
		logic [IW-1:0] arr;  // arrival index, zero-based
		logic [15:0]   s;
		logic [15:0]   w;
	} ent_t;

	typedef struct packed {
		logic [CW-1:0] succ;  // next sorted position plus one, 0 = none
		logic [CW-1:0] blen;
	} link_t;

	// held items in stable weight order, registered read
	ent_t  ent_mem [N];
	link_t link_mem [N];
	ent_t  ent_rd_q;
	link_t link_rd_q;
	logic [IW-1:0] raddr;

	ent_t          new_q;
	logic [IW-1:0] p_q, row_q;
	logic [CW-1:0] j_q, best_q, bsucc_q, maxl_q, pos_q;
	logic [15:0]   wi_q, si_q;
	logic          out_valid_q, out_end_q;
	logic [CW-1:0] out_len_q, out_item_q;

	always_comb begin
		raddr = '0;
		if (cmd.load)      raddr = IW'(count - CW'(1));
		if (cmd.shift)     raddr = p_q - IW'(2);
		if (cmd.row_start) raddr = row_q;
		if (cmd.row_cap)   raddr = j_q[IW-1:0];
		if (cmd.scan)      raddr = IW'(j_q + CW'(1));
		if (cmd.tr_read)   raddr = IW'(pos_q - CW'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.shift)
			ent_mem[p_q] <= ent_rd_q;
		else if (cmd.place)
			ent_mem[p_q] <= new_q;
		ent_rd_q <= ent_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.row_end)
			link_mem[row_q] <= {bsucc_q, best_q + CW'(1)};
		link_rd_q <= link_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_q       <= '0;
			p_q         <= '0;
			row_q       <= '0;
			j_q         <= '0;
			best_q      <= '0;
			bsucc_q     <= '0;
			maxl_q      <= '0;
			pos_q       <= '0;
			wi_q        <= '0;
			si_q        <= '0;
			out_valid_q <= 1'b0;
			out_end_q   <= 1'b0;
			out_len_q   <= '0;
			out_item_q  <= '0;
		end else begin
			if (cmd.load) begin
				new_q <= '{arr: count[IW-1:0], s: cmd.load_s, w: cmd.load_w};
				p_q   <= count[IW-1:0];
			end
			if (cmd.shift) p_q <= p_q - IW'(1);
			if (cmd.dp_init) begin
				row_q  <= IW'(count - CW'(1));
				maxl_q <= '0;
				pos_q  <= '0;
			end
			if (cmd.row_start) begin
				j_q     <= CW'(row_q) + CW'(1);
				best_q  <= '0;
				bsucc_q <= '0;
			end
			if (cmd.row_cap) begin
				wi_q <= ent_rd_q.w;
				si_q <= ent_rd_q.s;
			end
			if (cmd.scan) begin
				if (ent_rd_q.w > wi_q && ent_rd_q.s < si_q && link_rd_q.blen > best_q) begin
					best_q  <= link_rd_q.blen;
					bsucc_q <= j_q + CW'(1);
				end
				j_q <= j_q + CW'(1);
			end
			if (cmd.row_end) begin
				// sweep runs downwards: >= keeps the lowest row of maximal length
				if (best_q + CW'(1) >= maxl_q) begin
					maxl_q <= best_q + CW'(1);
					pos_q  <= CW'(row_q) + CW'(1);
				end
				if (row_q != '0) row_q <= row_q - IW'(1);
			end
			if (cmd.tr_load) begin
				out_valid_q <= 1'b1;
				out_len_q   <= maxl_q;
				out_item_q  <= CW'(ent_rd_q.arr) + CW'(1);
				out_end_q   <= link_rd_q.succ == '0;
				pos_q       <= link_rd_q.succ;
			end
			if (cmd.tr_pop) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.shift_ok  = p_q != '0 && ent_rd_q.w > new_q.w;
		stat.j_end     = j_q >= count;
		stat.j_last    = j_q + CW'(1) >= count;
		stat.row_zero  = row_q == '0;
		stat.out_valid = out_valid_q;
		stat.out_len   = out_len_q;
		stat.out_item  = out_item_q;
		stat.out_end   = out_end_q;
	end
endmodule

// File: hdl/ldc_control.sv
// ----------------------------------------------------------------------------
// ldc_control
// Input acceptance, item count, overflow flag and sequencing of the compute.
// ----------------------------------------------------------------------------
module ldc_control (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [15:0]        in_w,
	input  logic [15:0]        in_s,
	input  logic               in_last,
	output logic               in_ready,
	input  logic               out_ready,
	input  ldc_pkg::ldc_stat_t stat,
	output ldc_pkg::ldc_cmd_t  cmd,
	output logic [ldc_pkg::CNT_W-1:0] count,
	output logic               ovf
);
	typedef enum logic [3:0] {
		C_LOAD, C_INS, C_DPI, C_ROW, C_CAP, C_SCAN, C_ROWEND, C_TRR, C_TRL, C_TRH
	} cstate_t;
	cstate_t st_q;
	logic [ldc_pkg::CNT_W-1:0] cnt_q;
	logic ovf_q, last_q, acc, room;

	assign in_ready = st_q == C_LOAD;
	assign acc      = in_valid && in_ready;
	assign room     = cnt_q < ldc_pkg::CNT_W'(ldc_pkg::MAX_ITEMS);
	assign count    = cnt_q;
	assign ovf      = ovf_q;

	always_comb begin
		cmd        = '0;
		cmd.load_w = in_w;
		cmd.load_s = in_s;
		case (st_q)
			C_LOAD:   cmd.load = acc && room;
			C_INS: begin
				cmd.shift = stat.shift_ok;
				cmd.place = !stat.shift_ok;
			end
			C_DPI:    cmd.dp_init   = 1'b1;
			C_ROW:    cmd.row_start = 1'b1;
			C_CAP:    cmd.row_cap   = 1'b1;
			C_SCAN:   cmd.scan      = 1'b1;
			C_ROWEND: cmd.row_end   = 1'b1;
			C_TRR:    cmd.tr_read   = 1'b1;
			C_TRL:    cmd.tr_load   = 1'b1;
			C_TRH:    cmd.tr_pop    = out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= C_LOAD;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			last_q <= 1'b0;
		end else begin
			case (st_q)
				C_LOAD: begin
					if (acc) begin
						last_q <= in_last;
						if (room) begin
							cnt_q <= cnt_q + ldc_pkg::CNT_W'(1);
							st_q  <= C_INS;
						end else begin
							ovf_q <= 1'b1;
							if (in_last) st_q <= C_DPI;
						end
					end
				end
				C_INS: begin
					if (!stat.shift_ok) st_q <= last_q ? C_DPI : C_LOAD;
				end
				C_DPI:    st_q <= C_ROW;
				C_ROW:    st_q <= C_CAP;
				C_CAP:    st_q <= stat.j_end ? C_ROWEND : C_SCAN;
				C_SCAN: begin
					if (stat.j_last) st_q <= C_ROWEND;
				end
				C_ROWEND: st_q <= stat.row_zero ? C_TRR : C_ROW;
				C_TRR:    st_q <= C_TRL;
				C_TRL:    st_q <= C_TRH;
				C_TRH: begin
					if (out_ready) begin
						if (stat.out_end) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							st_q  <= C_LOAD;
						end else begin
							st_q <= C_TRR;
						end
					end
				end
				default: st_q <= C_LOAD;
			endcase
		end
	end
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sets of (weight, speed) words into the dominance chain unit, predicts
// the chain for each closing word and checks every result word in order.
// ----------------------------------------------------------------------------

class chain_scoreboard;
	logic [15:0] wt[$];
	logic [15:0] sp[$];
	bit          dropped;
	logic [15:0] exp_q[$];
	bit          exp_last_q[$];
	bit          exp_ovf_q[$];
	int          mismatches;

	// note an accepted input word; on the closing word compute the chain
	function void note_item(logic [15:0] w, logic [15:0] s, bit last);
		int n, a, b, cur, best, succ, maxlen, start, pos, k;
		int order[64];
		int blen[64];
		int nxt[64];
		if (wt.size() < ldc_pkg::MAX_ITEMS) begin
			wt.push_back(w);
			sp.push_back(s);
		end else
			dropped = 1'b1;
		if (!last)
			return;
		n = wt.size();
		for (a = 0; a < n; a++)
			order[a] = a;
		// stable insertion sort on weight
		for (a = 1; a < n; a++) begin
			cur = order[a];
			b = a;
			while (b > 0 && wt[order[b-1]] > wt[cur]) begin
				order[b] = order[b-1];
				b--;
			end
			order[b] = cur;
		end
		for (a = n - 1; a >= 0; a--) begin
			best = 0;
			succ = 0;
			for (b = a + 1; b < n; b++)
				if (wt[order[b]] > wt[order[a]] && sp[order[b]] < sp[order[a]]
				    && blen[b] > best) begin
					best = blen[b];
					succ = b + 1;
				end
			blen[a] = best + 1;
			nxt[a] = succ;
		end
		maxlen = 0;
		start = 0;
		for (a = 0; a < n; a++)
			if (blen[a] > maxlen) begin
				maxlen = blen[a];
				start = a;
			end
		pos = start + 1;
		k = 0;
		while (pos != 0 && pos <= n && k < ldc_pkg::MAX_ITEMS) begin
			exp_q.push_back({2'b00, 7'(order[pos-1] + 1), 7'(maxlen)});
			exp_ovf_q.push_back(dropped);
			pos = nxt[pos-1];
			exp_last_q.push_back(pos == 0 || pos > n);
			k++;
		end
		if (k > 0)
			exp_last_q[exp_last_q.size()-1] = 1'b1;
		wt.delete();
		sp.delete();
		dropped = 1'b0;
	endfunction

	function void check_result(logic [15:0] d, logic ovf, logic lst);
		logic [15:0] ed;
		bit el, eo;
		if (exp_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result word data=%h user=%b last=%b", d, ovf, lst);
			return;
		end
		ed = exp_q.pop_front();
		el = exp_last_q.pop_front();
		eo = exp_ovf_q.pop_front();
		if (d !== ed || ovf !== eo || lst !== el) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp data=%h user=%b last=%b got data=%h user=%b last=%b",
				         ed, eo, el, d, ovf, lst);
		end
	endfunction
endclass

module tb_top;
	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [15:0] weight, [31:16] speed
	logic        s_tlast;   // last_item
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [6:0] chain_length, [13:7] item_number, [15:14] 0
	logic        m_tuser;   // overflow
	logic        m_tlast;   // end_of_chain

	chain_scoreboard sb;
	int  cycles;
	localparam int LIMIT = 4000000;

	longest_dominance_chain_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// drive one word after a random idle gap (sometimes none), hold until accepted
	task automatic send_word(logic [15:0] w, logic [15:0] s, bit last);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {s, w};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_item(w, s, last);
		@(negedge clk);
	endtask

	task automatic send_set(int n, int mode);
		int i;
		logic [15:0] w, s;
		for (i = 0; i < n; i++) begin
			case (mode)
				0: begin w = 16'($urandom); s = 16'($urandom); end
				1: begin w = 16'($urandom_range(0, 7)); s = 16'($urandom_range(0, 7)); end
				default: begin
					w = 16'(i * 97 + $urandom_range(0, 200));
					s = 16'hFFFF - w;
				end
			endcase
			send_word(w, s, i == n - 1);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		while (sb.exp_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// receiver: random stalls per word
	initial begin
		int stall;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				m_tready <= 0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata, m_tuser, m_tlast);
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int n;
		sb = new();
		arst_n   = 0;
		s_tvalid = 0;
		s_tdata  = 0;
		s_tlast  = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: single item, extremes, ties, short chain; overflow set further on
		send_word(16'h0000, 16'hFFFF, 1);
		send_word(16'hFFFF, 16'h0000, 0);
		send_word(16'h0000, 16'hFFFF, 0);
		send_word(16'hFFFF, 16'h0000, 1);
		send_word(16'h0005, 16'h0005, 0);
		send_word(16'h0005, 16'h0005, 0);
		send_word(16'h0005, 16'h0005, 1);
		send_word(16'h0001, 16'h0009, 0);
		send_word(16'h0002, 16'h0008, 0);
		send_word(16'h0001, 16'h0007, 0);
		send_word(16'h0003, 16'h0006, 1);
		// pause until every result has come
		wait_drained();
		send_set(ldc_pkg::MAX_ITEMS, 2);
		send_set(ldc_pkg::MAX_ITEMS + 3, 0);
		wait_drained();
		sent = 11 + 2 * ldc_pkg::MAX_ITEMS + 3;
		while (sent < 450) begin
			n = $urandom_range(0, 9) == 0 ? $urandom_range(40, 70) : $urandom_range(1, 12);
			send_set(n, $urandom_range(0, 2));
			sent += n;
		end
		wait_drained();
		if (sb.mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
